FILE: rtl/canf_pkg.sv
// ----------------------------------------------------------------------------
// canf_pkg
// Shared types and constants for the CAN receive acceptance filter table.
// ----------------------------------------------------------------------------
package canf_pkg;

    localparam int FILTER_ENTRIES = 32;
    // entry_index is 5 bits wide, so no more than 32 entries are reachable
    localparam int INDEX_LIMIT    = 32;
    localparam int SEARCH_MAX     = (FILTER_ENTRIES < INDEX_LIMIT) ? FILTER_ENTRIES
                                                                   : INDEX_LIMIT;
    localparam int IDX_W          = (SEARCH_MAX > 1) ? $clog2(SEARCH_MAX) : 1;
    localparam int CNT_W          = $clog2(SEARCH_MAX + 1);

    localparam int ID_W           = 16;
    localparam int ENTRY_W        = 2 * ID_W + 1;
    localparam int CFG_ENTRIES_W  = 6;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [ADDR_W-1:0] REG_ENTRIES_IN_USE = 3'd0;
    localparam logic [ADDR_W-1:0] REG_NORMAL_MODE    = 3'd4;

    // cleared entry: identifier 0, mask all ones, no handler
    localparam logic [ENTRY_W-1:0] ENTRY_RESET = {1'b0, {ID_W{1'b1}}, {ID_W{1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FRAME = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_ILLEGAL = 2'd1,
        STS_SKIPPED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  entry_index;
        logic [15:0] filter_ident;
        logic [15:0] filter_mask;
        logic [28:0] frame_id;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       matched;
        logic [4:0] match_index;
        logic       delivered;
    } result_t;

endpackage

FILE: rtl/canf_ram.sv
// ----------------------------------------------------------------------------
// canf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module canf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/can_rx_mask_filter_table.sv
// ----------------------------------------------------------------------------
// can_rx_mask_filter_table
// CAN receive acceptance filter: identifier/mask table with first-match search.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carries one operation per transaction: write a
//   filter entry, look up a received frame ID, or clear the table. Every
//   transaction returns exactly one result on result/result_valid/result_stall.
//   The APB port holds entries_in_use (0x0) and normal_mode (0x4).
// Sequencing:
//   Write, clear, skipped frames, unknown codes and lookups with no entries in
//   use go from idle to the done state, then to the output register. A frame
//   lookup reads one table entry per cycle from the entry RAM (registered read
//   data) and compares each once its read returns; the search ends on the first
//   hit or after the last of lim entries, lim being entries_in_use capped at the table size.
//   One item is worked on at a time; the next one is taken as soon as the
//   result has moved to the output register, even if that is still stalled.
// Reset:
//   All entries read as cleared (ident 0, mask all ones, no handler) through
//   per-entry valid flops; a clear operation drops all of them together. No
//   clearing pass is needed. Both registers reset to 0.
// Stall:
//   A stalled result holds; the block finishes its current item and then
//   stalls its input until the output register frees up.
// ----------------------------------------------------------------------------
module can_rx_mask_filter_table
    import canf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,

    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result
);

    // configuration
    logic [CFG_ENTRIES_W-1:0] entries_in_use_reg;
    logic                     normal_mode_reg;
    logic                     cfg_wr;

    // control
    state_t                   state_reg, state_next;
    logic [SEARCH_MAX-1:0]    entry_valid_reg;
    logic [CNT_W-1:0]         addr_reg, addr_next;
    logic                     rd_pend_reg;
    logic                     rd_ent_valid_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [ID_W-1:0]          fid_reg;
    result_t                  res_reg, res_next;
    logic                     res_load;
    logic                     result_valid_reg;

    // datapath
    logic                     accept;
    logic [CNT_W-1:0]         lim;
    logic                     wr_ok;
    logic                     ram_we;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_waddr;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [ENTRY_W-1:0]       entry;
    logic [ID_W-1:0]          ent_ident;
    logic [ID_W-1:0]          ent_mask;
    logic                     ent_handler;
    logic                     hit;
    logic                     go_search;
    logic                     search_end;
    logic                     out_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
            normal_mode_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NORMAL_MODE[2])
            begin
                normal_mode_reg <= pwdata[0];
            end
            else
            begin
                entries_in_use_reg <= pwdata[CFG_ENTRIES_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_NORMAL_MODE[2])
        begin
            prdata = DATA_W'(normal_mode_reg);
        end
        else
        begin
            prdata = DATA_W'(entries_in_use_reg);
        end
    end

    // ---------------- table ----------------
    assign lim = (entries_in_use_reg > CFG_ENTRIES_W'(SEARCH_MAX)) ? CNT_W'(SEARCH_MAX)
                                                                   : CNT_W'(entries_in_use_reg);

    assign accept    = item_valid && !item_stall;
    assign wr_ok     = ({1'b0, item.entry_index} < CFG_ENTRIES_W'(lim));
    assign ram_we    = accept && (item.operation == OP_WRITE) && wr_ok;
    assign ram_waddr = IDX_W'(item.entry_index);
    assign ram_wdata = {1'b1, item.filter_mask, item.filter_ident};
    assign ram_raddr = addr_reg[IDX_W-1:0];

    canf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SEARCH_MAX)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry never written since reset or clear reads as the cleared value
    assign entry       = rd_ent_valid_reg ? ram_rdata : ENTRY_RESET;
    assign ent_ident   = entry[ID_W-1:0];
    assign ent_mask    = entry[2*ID_W-1:ID_W];
    assign ent_handler = entry[ENTRY_W-1];
    assign hit         = rd_pend_reg && (((fid_reg ^ ent_ident) & ent_mask) == '0);
    // all entries issued and the last one compared without a hit
    assign search_end  = (addr_reg >= lim) && !hit;

    assign go_search   = (item.operation == OP_FRAME) && normal_mode_reg && (lim != '0);
    assign out_free    = !result_valid_reg || !result_stall;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = go_search ? ST_SEARCH : ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (hit || search_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        item_stall = 1'b1;
        ram_re     = 1'b0;
        addr_next  = addr_reg;
        res_next   = res_reg;
        res_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                addr_next  = '0;
                if (accept)
                begin
                    res_load = 1'b1;
                    res_next = '0;
                    case (item.operation)
                        OP_WRITE:
                        begin
                            res_next.status = wr_ok ? STS_OK : STS_ILLEGAL;
                        end
                        OP_FRAME:
                        begin
                            res_next.status = normal_mode_reg ? STS_OK : STS_SKIPPED;
                        end
                        default:
                        begin
                            res_next.status = STS_OK;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    res_load             = 1'b1;
                    res_next.matched     = 1'b1;
                    res_next.match_index = 5'(rd_idx_reg);
                    res_next.delivered   = ent_handler;
                end
                else if (addr_reg < lim)
                begin
                    ram_re    = 1'b1;
                    addr_next = addr_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entry_valid_reg  <= '0;
            addr_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            rd_ent_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            rd_pend_reg      <= ram_re;
            rd_ent_valid_reg <= entry_valid_reg[ram_raddr];
            if (accept && (item.operation == OP_CLEAR))
            begin
                entry_valid_reg <= '0;
            end
            else if (ram_we)
            begin
                entry_valid_reg[ram_waddr] <= 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fid_reg <= item.frame_id[ID_W-1:0];
        end
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            result <= res_reg;
        end
    end

    assign result_valid = result_valid_reg;

    // ---------------- assertions ----------------
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");

    a_match_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.matched) |-> (result.status == STS_OK))
        else $error("matched result with non-ok status");

    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.matched) |-> (CNT_W'(result.match_index) < lim))
        else $error("match index beyond entries in use");

    a_search_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (normal_mode_reg && (lim != '0)))
        else $error("search running with an empty table or outside normal mode");

endmodule

FILE: tb/can_rx_mask_filter_table_tb.sv
// ----------------------------------------------------------------------------
// can_rx_mask_filter_table_tb
// Self-checking testbench for the CAN acceptance filter table.
// Drives entry writes, frame lookups, table clears and unknown codes through
// the valid/stall item port. A filter table model in the scoreboard predicts
// every result, and each result is checked in order as it leaves the block.
// The APB registers are changed between phases while the block is idle.
// Both handshakes get random gaps and stalls.
// ----------------------------------------------------------------------------
module can_rx_mask_filter_table_tb
    import canf_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 150;

    // ------------------------------------------------------------------------
    // Filter table model and result scoreboard
    // ------------------------------------------------------------------------
    class filter_table_model;
        logic [15:0] ident_tbl [FILTER_ENTRIES];
        logic [15:0] mask_tbl [FILTER_ENTRIES];
        bit          handler_tbl [FILTER_ENTRIES];
        logic [5:0]  entries_in_use;
        bit          normal_mode;
        result_t     pending_results[$];
        int          errors;

        function new();
            clear_entries();
            entries_in_use = '0;
            normal_mode    = 1'b0;
            errors         = 0;
        endfunction

        function void clear_entries();
            for (int i = 0; i < FILTER_ENTRIES; i++)
            begin
                ident_tbl[i]   = '0;
                mask_tbl[i]    = '1;
                handler_tbl[i] = 1'b0;
            end
        endfunction

        function int search_limit();
            int lim;
            lim = int'(entries_in_use);
            if (lim > SEARCH_MAX)
                lim = SEARCH_MAX;
            return lim;
        endfunction

        function void set_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
            if (addr == REG_ENTRIES_IN_USE)
                entries_in_use = value[5:0];
            else if (addr == REG_NORMAL_MODE)
                normal_mode = value[0];
        endfunction

        // transaction accepted on the item port: update the table, queue result
        function void note_item(item_t it);
            result_t     res;
            int          lim;
            logic [15:0] fid;
            res = '0;
            lim = search_limit();
            fid = it.frame_id[15:0];
            case (it.operation)
                OP_WRITE:
                begin
                    if (it.entry_index < lim)
                    begin
                        ident_tbl[it.entry_index]   = it.filter_ident;
                        mask_tbl[it.entry_index]    = it.filter_mask;
                        handler_tbl[it.entry_index] = 1'b1;
                        res.status = STS_OK;
                    end
                    else
                        res.status = STS_ILLEGAL;
                end
                OP_FRAME:
                begin
                    if (!normal_mode)
                        res.status = STS_SKIPPED;
                    else
                    begin
                        for (int i = 0; i < lim; i++)
                        begin
                            if (((fid ^ ident_tbl[i]) & mask_tbl[i]) == 16'h0)
                            begin
                                res.matched     = 1'b1;
                                res.match_index = i[4:0];
                                res.delivered   = handler_tbl[i];
                                break;
                            end
                        end
                    end
                end
                OP_CLEAR:
                    clear_entries();
                default:
                    ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d matched=%0d index=%0d delivered=%0d",
                         $time, got.status, got.matched, got.match_index, got.delivered);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status || got.matched !== exp.matched ||
                got.match_index !== exp.match_index || got.delivered !== exp.delivered)
            begin
                $display({"%0t: result mismatch: expected status=%0d matched=%0d ",
                          "index=%0d delivered=%0d, got status=%0d matched=%0d ",
                          "index=%0d delivered=%0d"},
                         $time, exp.status, exp.matched, exp.match_index, exp.delivered,
                         got.status, got.matched, got.match_index, got.delivered);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid;
    logic              item_stall;
    item_t             in_item;
    logic              result_valid;
    logic              result_stall;
    result_t           out_result;

    filter_table_model filters;
    int                cycle_count;
    int                quiet_left;

    can_rx_mask_filter_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (in_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (out_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            filters.check_result(out_result);
    end

    // result stall: free stretches, short stalls, a few long ones
    initial
    begin
        int hold;
        int pick;
        result_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    result_stall = 1'b0;
                    hold = $urandom_range(0, 40);
                end
                else if (pick < 90)
                begin
                    result_stall = 1'b1;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    result_stall = 1'b1;
                    hold = $urandom_range(10, 60);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int item_gap();
        int pick;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
            quiet_left = $urandom_range(10, 40);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = item_gap();
        repeat (gap)
        begin
            @(negedge clk);
            item_valid = 1'b0;
        end
        @(negedge clk);
        in_item    = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        filters.note_item(it);
    endtask

    task automatic stop_items();
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        filters.set_register(addr, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_drained();
        while (filters.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input int entries, input bit normal);
        wait_drained();
        reg_write(REG_ENTRIES_IN_USE, DATA_W'(entries));
        reg_write(REG_NORMAL_MODE, DATA_W'(normal));
    endtask

    function automatic item_t make_item(input logic [1:0] op, input logic [4:0] idx,
                                        input logic [15:0] ident, input logic [15:0] mask,
                                        input logic [28:0] fid);
        item_t it;
        it.operation    = op;
        it.entry_index  = idx;
        it.filter_ident = ident;
        it.filter_mask  = mask;
        it.frame_id     = fid;
        return it;
    endfunction

    // mostly writes to entries in use and frames aimed at stored entries
    function automatic item_t random_item();
        item_t       it;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        int          pick;
        int          lim;
        int          k;
        r0 = $urandom;
        r1 = $urandom;
        r2 = $urandom;
        it = make_item(r0[1:0], r0[6:2], r1[15:0], r1[31:16], r2[28:0]);
        lim  = filters.search_limit();
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            it.operation = OP_WRITE;
            if (lim > 0 && $urandom_range(0, 9) != 0)
                it.entry_index = 5'($urandom_range(0, lim - 1));
            pick = $urandom_range(0, 99);
            if (pick < 30)
                it.filter_mask = 16'hFFFF;
            else if (pick < 50)
                it.filter_mask = it.filter_mask | 16'hFF00;
            else if (pick < 54)
                it.filter_mask = 16'h0000;
            else if (pick < 75)
                it.filter_mask = it.filter_mask | r2[31:16];
        end
        else if (pick < 93)
        begin
            it.operation = OP_FRAME;
            if ($urandom_range(0, 99) < 65)
            begin
                k = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 31);
                it.frame_id[15:0] = (filters.ident_tbl[k] & filters.mask_tbl[k]) |
                                    (r1[31:16] & ~filters.mask_tbl[k]);
            end
        end
        else if (pick < 96)
            it.operation = OP_CLEAR;
        else
            it.operation = 2'd3;
        return it;
    endfunction

    task automatic run_phase(input int entries, input bit normal, input int count);
        configure(entries, normal);
        repeat (count)
            send_item(random_item());
        stop_items();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        filters     = new();
        cycle_count = 0;
        quiet_left  = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_valid  = 1'b0;
        in_item     = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset config: no entries in use, lookups skipped
        send_item(make_item(OP_WRITE, 5'd0, 16'h1234, 16'hFFFF, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'd0));
        send_item(make_item(2'd3, 5'd0, 16'h0, 16'h0, 29'd0));
        send_item(make_item(OP_CLEAR, 5'd0, 16'h0, 16'h0, 29'd0));
        stop_items();

        configure(32, 1'b1);
        // cleared table: ID 0 hits entry 0 without a handler, others miss
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h0000FFFF));
        send_item(make_item(OP_WRITE, 5'd31, 16'hFFFF, 16'hFFFF, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h1FFFFFFF));
        send_item(make_item(OP_WRITE, 5'd0, 16'hAAAA, 16'h0000, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h1FFF5555));
        send_item(make_item(OP_CLEAR, 5'd31, 16'hFFFF, 16'hFFFF, 29'h1FFFFFFF));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h00001234));
        send_item(make_item(OP_WRITE, 5'd7, 16'h1234, 16'hFF00, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h000012AB));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h000013AB));
        send_item(make_item(2'd3, 5'd31, 16'hFFFF, 16'hFFFF, 29'h1FFFFFFF));
        stop_items();

        // register above the table size saturates; lookups off
        configure(63, 1'b0);
        send_item(make_item(OP_WRITE, 5'd31, 16'h0F0F, 16'hF0F0, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h00000F0F));
        stop_items();

        configure(1, 1'b1);
        send_item(make_item(OP_WRITE, 5'd1, 16'h0001, 16'hFFFF, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h00000F0F));
        send_item(make_item(OP_WRITE, 5'd0, 16'h0F0F, 16'hFFFF, 29'd0));
        send_item(make_item(OP_FRAME, 5'd0, 16'h0, 16'h0, 29'h10000F0F));
        stop_items();

        run_phase(32, 1'b1, PHASE_ITEMS);
        run_phase(63, 1'b1, PHASE_ITEMS);
        run_phase(1, 1'b1, PHASE_ITEMS);
        run_phase(0, 1'b1, PHASE_ITEMS / 3);
        run_phase(20, 1'b0, PHASE_ITEMS / 3);
        run_phase(20, 1'b1, PHASE_ITEMS);
        run_phase($urandom_range(2, 31), 1'b1, PHASE_ITEMS);

        wait_drained();
        repeat (40) @(posedge clk);
        if (filters.errors == 0 && filters.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
